@@ rtl/speck_block_encrypt_top_macros.svh @@
// Assertion helpers used by the cipher round cell.
`ifndef SPECK_BLOCK_ENCRYPT_TOP_MACROS_SVH
`define SPECK_BLOCK_ENCRYPT_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SBE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sbe_pkg.sv @@
package sbe_pkg;

	localparam int unsigned WORD_W     = 64;
	localparam int unsigned KEY_WORDS  = 4;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned ROUNDS_DEF = 34;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;

	// Data and schedule words carried down the round chain.
	// l0 is the head of the schedule queue.
	typedef struct packed {
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] rk;
		logic [WORD_W-1:0] l0;
		logic [WORD_W-1:0] l1;
		logic [WORD_W-1:0] l2;
	} round_t;

	function automatic logic [WORD_W-1:0] ror8(input logic [WORD_W-1:0] v);
		return {v[7:0], v[WORD_W-1:8]};
	endfunction

	function automatic logic [WORD_W-1:0] rol3(input logic [WORD_W-1:0] v);
		return {v[WORD_W-4:0], v[WORD_W-1:WORD_W-3]};
	endfunction

endpackage

@@ rtl/sbe_cell.sv @@
`include "speck_block_encrypt_top_macros.svh"

module sbe_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_in,
	input  sbe_pkg::round_t state_in,
	input  logic            ready_in,
	output logic            ready,
	output logic            valid_out,
	output sbe_pkg::round_t state_out
);

	localparam logic [sbe_pkg::WORD_W-1:0] RC = sbe_pkg::WORD_W'(IDX);

	logic                          vld_s1;
	sbe_pkg::round_t               st_s1;
	sbe_pkg::round_t               nxt;
	logic [sbe_pkg::WORD_W-1:0]    nl;

	// One cipher round and one schedule step, side by side
	always_comb begin
		nxt.x  = state_in.rk ^ (state_in.y + sbe_pkg::ror8(state_in.x));
		nxt.y  = nxt.x ^ sbe_pkg::rol3(state_in.y);
		nl     = (sbe_pkg::ror8(state_in.l0) + state_in.rk) ^ RC;
		nxt.rk = nl ^ sbe_pkg::rol3(state_in.rk);
		nxt.l0 = state_in.l1;
		nxt.l1 = state_in.l2;
		nxt.l2 = nl;
	end

	assign ready     = !vld_s1 || ready_in;
	assign valid_out = vld_s1;
	assign state_out = st_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ready) begin
			vld_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid_in) begin
			st_s1 <= nxt;
		end
	end

	`SBE_ASSERT_NEXT(a_hold, clk, arst_n, vld_s1 && !ready_in, vld_s1 && $stable(st_s1), "stalled word lost or changed")
	`SBE_ASSERT_NEXT(a_take, clk, arst_n, valid_in && ready, vld_s1, "accepted word not captured")
	`SBE_ASSERT_NEXT(a_drain, clk, arst_n, vld_s1 && ready_in && !valid_in, !vld_s1, "word repeated after handoff")

endmodule

@@ rtl/speck_block_encrypt_top.sv @@
// Channel  Handshake              Payload
// in       in_valid / in_stall    plain_low (y), plain_high (x)
// out      out_valid / out_stall  cipher_low (y), cipher_high (x)
// cfg      cfg_we                 cfg_idx, cfg_wdata (key_word_0..3)
//
// One word enters per cycle while in_stall is low, and the chain has
// one register stage per round cell, each doing one round and one key step.
// Reset clears the key words to zero and empties every stage.
// A stall on the output holds the last stage; stages behind it keep filling
// bubbles, and in_stall rises only when every stage holds a word.
module speck_block_encrypt_top #(
	parameter int unsigned ROUNDS = sbe_pkg::ROUNDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [sbe_pkg::WORD_W-1:0]      plain_low,
	input  logic [sbe_pkg::WORD_W-1:0]      plain_high,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [sbe_pkg::WORD_W-1:0]      cipher_low,
	output logic [sbe_pkg::WORD_W-1:0]      cipher_high,
	input  logic                            cfg_we,
	input  logic [sbe_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [sbe_pkg::WORD_W-1:0]      cfg_wdata
);

	logic [sbe_pkg::WORD_W-1:0] key_q [sbe_pkg::KEY_WORDS];

	// Chain links: link i feeds cell i, link ROUNDS is the output
	logic            vld_c [ROUNDS+1];
	logic            rdy_c [ROUNDS+1];
	sbe_pkg::round_t st_c  [ROUNDS+1];

	// Key registers; writes past the last key word drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sbe_pkg::KEY_WORDS; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_idx)
				sbe_pkg::REG_KEY0: key_q[0] <= cfg_wdata;
				sbe_pkg::REG_KEY1: key_q[1] <= cfg_wdata;
				sbe_pkg::REG_KEY2: key_q[2] <= cfg_wdata;
				sbe_pkg::REG_KEY3: key_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Entry: the plaintext word plus the raw key, expanded along the chain
	assign vld_c[0]    = in_valid;
	assign st_c[0].x   = plain_high;
	assign st_c[0].y   = plain_low;
	assign st_c[0].rk  = key_q[0];
	assign st_c[0].l0  = key_q[1];
	assign st_c[0].l1  = key_q[2];
	assign st_c[0].l2  = key_q[3];
	assign in_stall    = !rdy_c[0];

	for (genvar g = 0; g < ROUNDS; g++) begin : g_round
		sbe_cell #(
			.IDX(g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (vld_c[g]),
			.state_in  (st_c[g]),
			.ready_in  (rdy_c[g+1]),
			.ready     (rdy_c[g]),
			.valid_out (vld_c[g+1]),
			.state_out (st_c[g+1])
		);
	end

	// Exit: the last cell's register is the output register
	assign rdy_c[ROUNDS] = !out_stall;
	assign out_valid     = vld_c[ROUNDS];
	assign cipher_low    = st_c[ROUNDS].y;
	assign cipher_high   = st_c[ROUNDS].x;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

// Block cipher encryptor check.
// A driver and a monitor run as clocked processes around the round chain.
// The driver takes plaintext words from a queue that the stimulus process
// fills. It predicts each ciphertext at the edge where the word is accepted.
// The monitor compares each ciphertext word that leaves the chain with the
// oldest prediction.
module tb;
	import sbe_pkg::*;

	localparam int unsigned ROUNDS    = ROUNDS_DEF;
	localparam int unsigned LONG_HOLD = 200;

	// One 128-bit block: hi is the x word, lo is the y word.
	typedef struct packed {
		logic [WORD_W-1:0] hi;
		logic [WORD_W-1:0] lo;
	} block_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic [WORD_W-1:0]    plain_low   = '0;
	logic [WORD_W-1:0]    plain_high  = '0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic [WORD_W-1:0]    cipher_low;
	logic [WORD_W-1:0]    cipher_high;
	logic                 cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx     = '0;
	logic [WORD_W-1:0]    cfg_wdata   = '0;

	// Mirror of the key registers; they reset to zero.
	logic [WORD_W-1:0] key_words [KEY_WORDS] = '{default: '0};

	block_t pending_blocks[$];
	block_t expected_ciphers[$];

	int blocks_queued   = 0;
	int blocks_accepted = 0;
	int results_checked = 0;
	int mismatch_count  = 0;
	int in_stall_cycles = 0;
	int key_loads       = 0;

	// Idle controls, set by the stimulus process.
	bit tx_idle_en    = 1'b1;
	bit rx_idle_en    = 1'b1;
	bit long_hold_req = 1'b0;

	int tx_gap    = 0;
	int rx_gap    = 0;
	int hold_left = 0;

	speck_block_encrypt_top #(
		.ROUNDS(ROUNDS)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.plain_low  (plain_low),
		.plain_high (plain_high),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cipher_low (cipher_low),
		.cipher_high(cipher_high),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Encrypt one block under the mirrored key, expanding the round keys
	// as the rounds go. The three pending schedule words form a ring.
	function automatic block_t encrypt_block(input block_t plain);
		logic [WORD_W-1:0] x, y, rk, nl;
		logic [WORD_W-1:0] sched [3];
		int head;
		block_t res;
		x = plain.hi;
		y = plain.lo;
		rk = key_words[0];
		sched[0] = key_words[1];
		sched[1] = key_words[2];
		sched[2] = key_words[3];
		head = 0;
		for (int r = 0; r < ROUNDS; r++) begin
			x = rk ^ (y + {x[7:0], x[WORD_W-1:8]});
			y = x ^ {y[WORD_W-4:0], y[WORD_W-1:WORD_W-3]};
			// next round key: the round index goes into the new schedule word
			nl = ({sched[head][7:0], sched[head][WORD_W-1:8]} + rk) ^ WORD_W'(r);
			sched[head] = nl;
			head = (head + 1) % 3;
			rk = nl ^ {rk[WORD_W-4:0], rk[WORD_W-1:WORD_W-3]};
		end
		res.hi = x;
		res.lo = y;
		return res;
	endfunction

	// Mostly full random words, with zero, all ones and single bits mixed in.
	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			2: return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Driver: present the next plaintext word, hold it while stalled, and
	// predict its ciphertext at the edge where it goes in.
	always @(posedge clk) begin : drive_input
		block_t blk;
		if (arst_n) begin
			if (in_valid && in_stall) begin
				in_stall_cycles++;
			end
			if (in_valid && !in_stall) begin
				expected_ciphers.push_back(encrypt_block({plain_high, plain_low}));
				blocks_accepted++;
			end
			// The slot is free unless a word is stalled; a stalled word stays put.
			if (!in_valid || !in_stall) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (tx_idle_en && $urandom_range(0, 5) == 0) begin
					tx_gap = $urandom_range(0, 14);
					in_valid <= 1'b0;
				end else if (pending_blocks.size() > 0) begin
					blk = pending_blocks.pop_front();
					in_valid <= 1'b1;
					plain_low <= blk.lo;
					plain_high <= blk.hi;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each ciphertext word that leaves, then pick the stall
	// for the next cycle. A long hold lets the chain fill up and push back.
	always @(posedge clk) begin : watch_output
		block_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_ciphers.size() == 0) begin
					$display("%0t: unexpected cipher word: expected none, got %h %h",
						$time, cipher_high, cipher_low);
					mismatch_count++;
				end else begin
					want = expected_ciphers.pop_front();
					if (cipher_low !== want.lo) begin
						$display("%0t: cipher_low: expected %h, got %h",
							$time, want.lo, cipher_low);
						mismatch_count++;
					end
					if (cipher_high !== want.hi) begin
						$display("%0t: cipher_high: expected %h, got %h",
							$time, want.hi, cipher_high);
						mismatch_count++;
					end
					results_checked++;
				end
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_stall <= 1'b1;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				rx_gap = $urandom_range(0, 14);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Queue one plaintext word for the driver.
	task automatic send_block(input logic [WORD_W-1:0] hi, input logic [WORD_W-1:0] lo);
		block_t blk;
		blk.hi = hi;
		blk.lo = lo;
		pending_blocks.push_back(blk);
		blocks_queued++;
	endtask

	// Wait until every queued word has come back as ciphertext.
	task automatic drain();
		while (results_checked != blocks_queued) @(posedge clk);
	endtask

	// One register write; the mirror drops writes to unused indexes.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		if (idx < KEY_WORDS) key_words[idx[1:0]] = data;
	endtask

	// Load a full key, then write junk to an unused index, which must not stick.
	task automatic load_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
		input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
		write_reg(REG_KEY0, k0);
		write_reg(REG_KEY1, k1);
		write_reg(REG_KEY2, k2);
		write_reg(REG_KEY3, k3);
		write_reg(CFG_IDX_W'($urandom_range(KEY_WORDS, 2 ** CFG_IDX_W - 1)), rand_word());
		@(posedge clk);
		cfg_we <= 1'b0;
		key_loads++;
	endtask

	task automatic send_random(input int count);
		repeat (count) send_block(rand_word(), rand_word());
	endtask

	// Words at the extremes of both fields, plus alternating and single-bit patterns.
	task automatic send_corners();
		send_block('0, '0);
		send_block('1, '1);
		send_block('0, '1);
		send_block('1, '0);
		send_block({WORD_W/2{2'b01}}, {WORD_W/2{2'b10}});
		send_block(WORD_W'(1), {1'b1, {WORD_W-1{1'b0}}});
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: the reset key of all zeros first.
		send_corners();
		drain();

		// Byte-ramp key with the usual sample plaintext, and the corner words.
		load_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
			64'h1716151413121110, 64'h1f1e1d1c1b1a1918);
		send_block(64'h65736f6874206e49, 64'h202e72656e6f6f70);
		send_corners();
		drain();

		// Hit every unused index with zeros; the key must stay all ones.
		load_key('1, '1, '1, '1);
		for (int i = KEY_WORDS; i < 2 ** CFG_IDX_W; i++) begin
			write_reg(CFG_IDX_W'(i), '0);
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		send_corners();
		drain();

		// Random words under random and patterned keys, idle on both sides.
		load_key(rand_word(), rand_word(), rand_word(), rand_word());
		send_random(70);
		drain();

		load_key('1, '0, '1, '0);
		send_random(50);
		drain();

		// Receiver stalls only.
		tx_idle_en = 1'b0;
		load_key({$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom});
		send_random(60);
		drain();

		// Sender gaps only.
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b0;
		load_key('0, '1, '0, '1);
		send_random(50);
		drain();

		// Back pressure: hold the output long enough for the chain to fill
		// while the sender keeps offering words back to back.
		tx_idle_en = 1'b0;
		load_key(rand_word(), rand_word(), rand_word(), rand_word());
		long_hold_req = 1'b1;
		send_random(90);
		drain();

		// Both sides idle again under the all-zero key.
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		load_key('0, '0, '0, '0);
		send_random(20);
		drain();

		// Final stretch with no idling on either side.
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		load_key({$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom});
		send_random(50);
		drain();

		// Let the chain run empty and catch any stray output.
		repeat (ROUNDS + 10) @(posedge clk);
		if (expected_ciphers.size() != 0) begin
			$display("%0t: %0d cipher words never arrived", $time, expected_ciphers.size());
			mismatch_count++;
		end
		$display("Encrypted %0d blocks under %0d key loads, with reset key and unused indexes.",
			blocks_accepted, key_loads);
		$display("Input was held off for %0d cycles by back pressure.", in_stall_cycles);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("%0t: timeout, %0d of %0d blocks checked", $time, results_checked,
			blocks_queued);
		$display("Mismatches found");
		$finish;
	end

endmodule
